// ===== hdl/tpb_pkg.sv =====
// ----------------------------------------------------------------------------
// tpb_pkg
// Shared types, codes and colour matching for the tolerant palette builder.
// ----------------------------------------------------------------------------
package tpb_pkg;

   localparam int COLOR_W   = 24;
   localparam int INDEX_W   = 8;
   localparam int USED_W    = 9;
   localparam int ADDR_W    = 9;
   localparam int MODE_W    = 2;
   localparam int PRESET_COUNT = 4;

   localparam logic [MODE_W-1:0] MODE_MAP   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

   localparam logic [COLOR_W-1:0] PRESET_COLOR [PRESET_COUNT] = '{
      24'hC0C0C0, 24'hFFFFFF, 24'h808080, 24'h000000
   };

   typedef enum logic [2:0] {
      KIND_NONE,
      KIND_HIT,
      KIND_ADD,
      KIND_FULL,
      KIND_READ
   } out_kind_type;

   typedef struct packed {
      logic         load;
      logic         load_entry;
      logic         clear;
      logic         issue;
      logic         append;
      logic         out_load;
      out_kind_type kind;
   } cmd_type;

   typedef struct packed {
      logic rd_valid;
      logic hit;
      logic last;
      logic room;
      logic more;
   } status_type;

   function automatic logic channel_close(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] a_up;
      logic [7:0] b_up;
      a_up = a + 8'd1;
      b_up = b + 8'd1;
      if (a == b) begin
         return 1'b1;
      end
      if ((a == 8'hFF) || (b == 8'hFF)) begin
         return 1'b0;
      end
      return (a_up & 8'hFE) == (b_up & 8'hFE);
   endfunction

   function automatic logic color_close(input logic [COLOR_W-1:0] x,
                                        input logic [COLOR_W-1:0] y);
      return channel_close(x[23:16], y[23:16]) &&
             channel_close(x[15:8],  y[15:8])  &&
             channel_close(x[7:0],   y[7:0]);
   endfunction

endpackage

// ===== hdl/tpb_req_if.sv =====
// ----------------------------------------------------------------------------
// tpb_req_if
// Request channel: one beat carries a mode, a pixel and an entry number.
// ----------------------------------------------------------------------------
interface tpb_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [tpb_pkg::MODE_W-1:0]           mode;
   logic [tpb_pkg::COLOR_W-1:0]          pixel_color;
   logic [tpb_pkg::INDEX_W-1:0]          entry_number;

   modport source (output valid, output mode, output pixel_color, output entry_number,
                   input ready);
   modport sink   (input valid, input mode, input pixel_color, input entry_number,
                   output ready);
endinterface

// ===== hdl/tpb_rsp_if.sv =====
// ----------------------------------------------------------------------------
// tpb_rsp_if
// Response channel: one beat per request with index, flags, colour and count.
// ----------------------------------------------------------------------------
interface tpb_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [tpb_pkg::INDEX_W-1:0]          color_index;
   logic                                 matched_existing;
   logic                                 entry_added;
   logic                                 palette_full;
   logic [tpb_pkg::COLOR_W-1:0]          entry_color;
   logic [tpb_pkg::USED_W-1:0]           used_entries;

   modport source (output valid, output color_index, output matched_existing,
                   output entry_added, output palette_full, output entry_color,
                   output used_entries, input ready);
   modport sink   (input valid, input color_index, input matched_existing,
                   input entry_added, input palette_full, input entry_color,
                   input used_entries, output ready);
endinterface

// ===== hdl/tpb_datapath.sv =====
// ----------------------------------------------------------------------------
// tpb_datapath
// Palette memory, fill count, scan address, colour compare and result register.
// ----------------------------------------------------------------------------
module tpb_datapath #(
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  tpb_pkg::cmd_type                 cmd,
   output tpb_pkg::status_type              status,
   input  logic [tpb_pkg::COLOR_W-1:0]      req_pixel_color,
   input  logic [tpb_pkg::INDEX_W-1:0]      req_entry_number,
   output logic [tpb_pkg::INDEX_W-1:0]      rsp_color_index,
   output logic                             rsp_matched_existing,
   output logic                             rsp_entry_added,
   output logic                             rsp_palette_full,
   output logic [tpb_pkg::COLOR_W-1:0]      rsp_entry_color,
   output logic [tpb_pkg::USED_W-1:0]       rsp_used_entries
);

   localparam int AW = $clog2(PALETTE_ENTRIES);
   localparam int CW = $clog2(PALETTE_ENTRIES + 1);

   logic [tpb_pkg::COLOR_W-1:0] mem [PALETTE_ENTRIES];

   logic [tpb_pkg::COLOR_W-1:0] pix_ff;
   logic [tpb_pkg::ADDR_W-1:0]  addr_ff,   addr_in;
   logic [CW-1:0]               count_ff,  count_in;
   logic                        rd_valid_ff;
   logic [tpb_pkg::ADDR_W-1:0]  rd_idx_ff;
   logic [tpb_pkg::COLOR_W-1:0] mem_q_ff;

   logic [tpb_pkg::ADDR_W-1:0]  count_ext;
   logic [tpb_pkg::COLOR_W-1:0] rd_color;

   logic [tpb_pkg::INDEX_W-1:0] idx_ff,   idx_in;
   logic                        match_ff, match_in;
   logic                        added_ff, added_in;
   logic                        full_ff,  full_in;
   logic [tpb_pkg::COLOR_W-1:0] color_ff, color_in;
   logic [tpb_pkg::USED_W-1:0]  used_ff,  used_in;

   assign count_ext = tpb_pkg::ADDR_W'(count_ff);

   // Presets live outside the memory; entries past the fill count read as zero.
   always_comb begin
      priority if (rd_idx_ff < tpb_pkg::ADDR_W'(tpb_pkg::PRESET_COUNT)) begin
         rd_color = tpb_pkg::PRESET_COLOR[rd_idx_ff[1:0]];
      end else if (rd_idx_ff >= count_ext) begin
         rd_color = '0;
      end else begin
         rd_color = mem_q_ff;
      end
   end

   always_comb begin
      status.rd_valid = rd_valid_ff;
      status.hit      = rd_valid_ff && tpb_pkg::color_close(pix_ff, rd_color);
      status.last     = (rd_idx_ff == (count_ext - tpb_pkg::ADDR_W'(1)));
      status.room     = (count_ff != CW'(PALETTE_ENTRIES));
      status.more     = (addr_ff < count_ext);
   end

   always_comb begin
      addr_in  = addr_ff;
      count_in = count_ff;
      if (cmd.load) begin
         addr_in = cmd.load_entry ? tpb_pkg::ADDR_W'(req_entry_number) : '0;
      end else if (cmd.issue) begin
         addr_in = addr_ff + tpb_pkg::ADDR_W'(1);
      end
      if (cmd.clear) begin
         count_in = CW'(tpb_pkg::PRESET_COUNT);
      end else if (cmd.append) begin
         count_in = count_ff + CW'(1);
      end
   end

   always_comb begin
      idx_in   = '0;
      match_in = 1'b0;
      added_in = 1'b0;
      full_in  = 1'b0;
      color_in = '0;
      used_in  = tpb_pkg::USED_W'(count_ff);
      unique case (cmd.kind)
         tpb_pkg::KIND_HIT: begin
            idx_in   = rd_idx_ff[tpb_pkg::INDEX_W-1:0];
            match_in = 1'b1;
            color_in = rd_color;
         end
         tpb_pkg::KIND_ADD: begin
            idx_in   = tpb_pkg::INDEX_W'(count_ff);
            added_in = 1'b1;
            color_in = pix_ff;
            used_in  = tpb_pkg::USED_W'(count_ff) + tpb_pkg::USED_W'(1);
         end
         tpb_pkg::KIND_FULL: begin
            full_in  = 1'b1;
            color_in = tpb_pkg::PRESET_COLOR[0];
         end
         tpb_pkg::KIND_READ: begin
            idx_in   = rd_idx_ff[tpb_pkg::INDEX_W-1:0];
            color_in = rd_color;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= CW'(tpb_pkg::PRESET_COUNT);
         rd_valid_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         rd_valid_ff <= cmd.issue;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      if (cmd.load) begin
         pix_ff <= req_pixel_color;
      end
      if (cmd.issue) begin
         rd_idx_ff <= addr_ff;
      end
      if (cmd.out_load) begin
         idx_ff   <= idx_in;
         match_ff <= match_in;
         added_ff <= added_in;
         full_ff  <= full_in;
         color_ff <= color_in;
         used_ff  <= used_in;
      end
   end

   // Single-port palette memory: append writes, scan or read fetches.
   always_ff @(posedge clock) begin
      if (cmd.append) begin
         mem[count_ff[AW-1:0]] <= pix_ff;
      end
      if (cmd.issue) begin
         mem_q_ff <= mem[addr_ff[AW-1:0]];
      end
   end

   assign rsp_color_index      = idx_ff;
   assign rsp_matched_existing = match_ff;
   assign rsp_entry_added      = added_ff;
   assign rsp_palette_full     = full_ff;
   assign rsp_entry_color      = color_ff;
   assign rsp_used_entries     = used_ff;

endmodule

// ===== hdl/tpb_controller.sv =====
// ----------------------------------------------------------------------------
// tpb_controller
// Sequencer for request intake, palette scan, entry read and response hand-off.
// ----------------------------------------------------------------------------
module tpb_controller (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic [tpb_pkg::MODE_W-1:0]   req_mode,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  tpb_pkg::status_type          status,
   output tpb_pkg::cmd_type             cmd
);

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_SCAN    = 4'b0010,
      ST_READ    = 4'b0100,
      ST_RESPOND = 4'b1000
   } state_type;

   state_type               state_ff, state_in;
   tpb_pkg::out_kind_type   kind_ff,  kind_in;
   logic                    out_valid_ff, out_valid_in;
   logic                    slot_free;

   assign slot_free = !out_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = out_valid_ff;

   always_comb begin
      state_in        = state_ff;
      kind_in         = kind_ff;
      cmd             = '0;
      cmd.kind        = kind_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load       = 1'b1;
               cmd.load_entry = (req_mode == tpb_pkg::MODE_READ);
               cmd.clear      = (req_mode == tpb_pkg::MODE_CLEAR);
               kind_in        = tpb_pkg::KIND_NONE;
               if (req_mode == tpb_pkg::MODE_MAP) begin
                  state_in = ST_SCAN;
               end else if (req_mode == tpb_pkg::MODE_READ) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_RESPOND;
               end
            end
         end
         ST_SCAN: begin
            // Compare the entry fetched last cycle; stop fetching on a hit.
            priority if (status.hit) begin
               kind_in  = tpb_pkg::KIND_HIT;
               state_in = ST_RESPOND;
            end else if (status.rd_valid && status.last) begin
               kind_in  = status.room ? tpb_pkg::KIND_ADD : tpb_pkg::KIND_FULL;
               state_in = ST_RESPOND;
            end else begin
               cmd.issue = status.more;
            end
         end
         ST_READ: begin
            cmd.issue = 1'b1;
            kind_in   = tpb_pkg::KIND_READ;
            state_in  = ST_RESPOND;
         end
         ST_RESPOND: begin
            if (slot_free) begin
               cmd.out_load = 1'b1;
               cmd.append   = (kind_ff == tpb_pkg::KIND_ADD);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign out_valid_in = cmd.out_load || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         kind_ff      <= tpb_pkg::KIND_NONE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

// ===== hdl/tolerant_palette_builder_top.sv =====
// ----------------------------------------------------------------------------
// tolerant_palette_builder_top
// Maps RGB pixels to palette indices, growing the palette as it goes. A map
// beat scans the used entries in index order, one entry per cycle through the
// single read port of the palette memory, and takes the first entry whose
// channels all match within the rounding tolerance; an unmatched colour is
// appended while room remains, otherwise index 0 is returned with the full
// flag; a map beat stops scanning at the first match. The next request is
// taken while a finished response still waits in the output register. Presets
// are held as constants and unused entries read as zero, so reset and clear
// need no sweep.
// ----------------------------------------------------------------------------
module tolerant_palette_builder_top #(
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic          clock,
   input  logic          reset,
   tpb_req_if.sink       req_bus,
   tpb_rsp_if.source     rsp_bus
);

   tpb_pkg::cmd_type    cmd;
   tpb_pkg::status_type status;

   tpb_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_mode  (req_bus.mode),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   tpb_datapath #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_pixel_color      (req_bus.pixel_color),
      .req_entry_number     (req_bus.entry_number),
      .rsp_color_index      (rsp_bus.color_index),
      .rsp_matched_existing (rsp_bus.matched_existing),
      .rsp_entry_added      (rsp_bus.entry_added),
      .rsp_palette_full     (rsp_bus.palette_full),
      .rsp_entry_color      (rsp_bus.entry_color),
      .rsp_used_entries     (rsp_bus.used_entries)
   );

   a_used_range: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.used_entries >= tpb_pkg::USED_W'(tpb_pkg::PRESET_COUNT)) &&
                        (rsp_bus.used_entries <= tpb_pkg::USED_W'(PALETTE_ENTRIES)))
      else $error("used entry count out of range");

   a_one_outcome: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> $onehot0({rsp_bus.matched_existing, rsp_bus.entry_added,
                                  rsp_bus.palette_full}))
      else $error("more than one map outcome flagged");

   a_add_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.entry_added) |->
         (tpb_pkg::USED_W'(rsp_bus.color_index) + tpb_pkg::USED_W'(1) == rsp_bus.used_entries))
      else $error("appended entry index does not match fill count");

   a_full_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.palette_full) |->
         (rsp_bus.color_index == '0) &&
         (rsp_bus.used_entries == tpb_pkg::USED_W'(PALETTE_ENTRIES)))
      else $error("full response without full palette or non-zero index");

endmodule

// ===== tb/sv/palette_scoreboard.sv =====
// ----------------------------------------------------------------------------
// palette_scoreboard
// Watches the request and response channels of the tolerant palette builder.
// Keeps its own copy of the palette, works out the response for every
// accepted request and compares each response beat, field by field, with the
// oldest outstanding one.
// ----------------------------------------------------------------------------
module palette_scoreboard #(
   parameter int CAPACITY = 256
) (
   input  logic        clock,
   input  logic        reset,
   tpb_req_if          req_mon,
   tpb_rsp_if          rsp_mon,
   output int unsigned fail_count,
   output int unsigned pending,
   output int unsigned n_hits,
   output int unsigned n_appends,
   output int unsigned n_fulls,
   output int unsigned n_reads,
   output int unsigned n_clears
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [tpb_pkg::INDEX_W-1:0] index;
      logic                        hit;
      logic                        added;
      logic                        full;
      logic [tpb_pkg::COLOR_W-1:0] colour;
      logic [tpb_pkg::USED_W-1:0]  used;
   } palette_answer_type;

   logic [tpb_pkg::COLOR_W-1:0] shadow_palette [256];
   logic [tpb_pkg::USED_W-1:0]  shadow_used;
   palette_answer_type          answers_q [$];
   palette_answer_type          want;
   palette_answer_type          got;
   int unsigned                 errors;
   int unsigned                 hits, appends, fulls, reads, clears;

   function automatic bit channels_close(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] a_inc;
      logic [7:0] b_inc;
      a_inc = a + 8'd1;
      b_inc = b + 8'd1;
      if (a == b) begin
         return 1'b1;
      end
      // saturated channels only ever match exactly
      return (a != 8'hFF) && (b != 8'hFF) && (a_inc[7:1] == b_inc[7:1]);
   endfunction

   function automatic bit colours_close(input logic [tpb_pkg::COLOR_W-1:0] x,
                                        input logic [tpb_pkg::COLOR_W-1:0] y);
      bit all_close;
      all_close = 1'b1;
      for (int ch = 0; ch < 3; ch++) begin
         all_close &= channels_close(x[8*ch +: 8], y[8*ch +: 8]);
      end
      return all_close;
   endfunction

   task automatic load_presets();
      for (int e = 0; e < 256; e++) begin
         shadow_palette[e] = (e < tpb_pkg::PRESET_COUNT) ? tpb_pkg::PRESET_COLOR[e] : '0;
      end
      shadow_used = tpb_pkg::USED_W'(tpb_pkg::PRESET_COUNT);
   endtask

   task automatic resolve_beat(input  logic [tpb_pkg::MODE_W-1:0]  op,
                               input  logic [tpb_pkg::COLOR_W-1:0] pix,
                               input  logic [tpb_pkg::INDEX_W-1:0] num,
                               output palette_answer_type          ans);
      bit found;
      found = 1'b0;
      ans   = '0;
      case (op)
         tpb_pkg::MODE_MAP: begin
            for (int e = 0; e < 256; e++) begin
               if (!found && e < shadow_used && colours_close(pix, shadow_palette[e])) begin
                  found      = 1'b1;
                  ans.index  = tpb_pkg::INDEX_W'(e);
                  ans.colour = shadow_palette[e];
                  ans.hit    = 1'b1;
               end
            end
            if (!found) begin
               if (shadow_used < CAPACITY) begin
                  ans.index  = shadow_used[tpb_pkg::INDEX_W-1:0];
                  ans.colour = pix;
                  ans.added  = 1'b1;
                  shadow_palette[shadow_used[tpb_pkg::INDEX_W-1:0]] = pix;
                  shadow_used = shadow_used + tpb_pkg::USED_W'(1);
               end else begin
                  // no room: fall back on entry 0
                  ans.index  = '0;
                  ans.colour = shadow_palette[0];
                  ans.full   = 1'b1;
               end
            end
         end
         tpb_pkg::MODE_READ: begin
            ans.index  = num;
            ans.colour = shadow_palette[num];
         end
         tpb_pkg::MODE_CLEAR: begin
            load_presets();
         end
         default: begin
         end
      endcase
      ans.used = shadow_used;
   endtask

   task automatic compare_field(input string name,
                                input logic [tpb_pkg::COLOR_W-1:0] exp_val,
                                input logic [tpb_pkg::COLOR_W-1:0] act_val);
      if (act_val !== exp_val) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         load_presets();
         answers_q.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.color_index, rsp_mon.matched_existing, rsp_mon.entry_added,
                    rsp_mon.palette_full, rsp_mon.entry_color, rsp_mon.used_entries};
            if (answers_q.size() == 0) begin
               $error("response beat with no request outstanding");
               errors++;
            end else begin
               want = answers_q.pop_front();
               compare_field("color_index", tpb_pkg::COLOR_W'(want.index),
                             tpb_pkg::COLOR_W'(got.index));
               compare_field("matched_existing", tpb_pkg::COLOR_W'(want.hit),
                             tpb_pkg::COLOR_W'(got.hit));
               compare_field("entry_added", tpb_pkg::COLOR_W'(want.added),
                             tpb_pkg::COLOR_W'(got.added));
               compare_field("palette_full", tpb_pkg::COLOR_W'(want.full),
                             tpb_pkg::COLOR_W'(got.full));
               compare_field("entry_color", want.colour, got.colour);
               compare_field("used_entries", tpb_pkg::COLOR_W'(want.used),
                             tpb_pkg::COLOR_W'(got.used));
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            resolve_beat(req_mon.mode, req_mon.pixel_color, req_mon.entry_number, want);
            answers_q.push_back(want);
            if (req_mon.mode == tpb_pkg::MODE_READ) begin
               reads++;
            end else if (req_mon.mode == tpb_pkg::MODE_CLEAR) begin
               clears++;
            end else begin
               hits    += want.hit;
               appends += want.added;
               fulls   += want.full;
            end
         end
      end
      fail_count <= errors;
      pending    <= answers_q.size();
      n_hits     <= hits;
      n_appends  <= appends;
      n_fulls    <= fulls;
      n_reads    <= reads;
      n_clears   <= clears;
   end

endmodule

// ===== tb/sv/tolerant_palette_builder_top_tb.sv =====
// ----------------------------------------------------------------------------
// tolerant_palette_builder_top_tb
// Drives the palette builder with a directed opening (presets, tolerance
// edges, saturated channels, reads of used and unused entries, a clear) and
// then random segments, each starting with a clear, that mix fresh colours,
// near copies of recent colours, tricky channel levels and entry reads, so
// that the palette both stays small and fills up. Both sides idle in random
// bursts; the response side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tolerant_palette_builder_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          TOTAL_BEATS = 1850;
   localparam int          CALM_FROM   = TOTAL_BEATS * 85 / 100;
   localparam int          HOLD_AFTER  = 60;
   localparam int          HOLD_CYCLES = 700;
   localparam int          TAIL_CYCLES = 300;
   localparam int unsigned CYCLE_LIMIT = 3_000_000;

   localparam logic [7:0] TRICKY_LEVELS [9] = '{
      8'h00, 8'h01, 8'h7F, 8'h80, 8'hBF, 8'hC0, 8'hC1, 8'hFE, 8'hFF
   };

   logic clock = 1'b0;
   logic reset;

   tpb_req_if req_bus ();
   tpb_rsp_if rsp_bus ();

   int unsigned fail_count, pending;
   int unsigned n_hits, n_appends, n_fulls, n_reads, n_clears;

   int unsigned sent;
   int unsigned cycle_count;
   bit          calm;
   bit          gap_on;
   logic [tpb_pkg::COLOR_W-1:0] recent_colours [$];

   tolerant_palette_builder_top #(.PALETTE_ENTRIES(256)) uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   palette_scoreboard #(.CAPACITY(256)) pal_sb (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_bus),
      .rsp_mon    (rsp_bus),
      .fail_count (fail_count),
      .pending    (pending),
      .n_hits     (n_hits),
      .n_appends  (n_appends),
      .n_fulls    (n_fulls),
      .n_reads    (n_reads),
      .n_clears   (n_clears)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // offer one beat and hold it until the block takes it
   task automatic offer(input logic [tpb_pkg::MODE_W-1:0]  op,
                        input logic [tpb_pkg::COLOR_W-1:0] pix,
                        input logic [tpb_pkg::INDEX_W-1:0] num);
      if (!calm && gap_on && $urandom_range(0, 2) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.mode         <= op;
      req_bus.pixel_color  <= pix;
      req_bus.entry_number <= num;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      sent++;
      calm = (sent >= CALM_FROM);
      if (op == tpb_pkg::MODE_MAP) begin
         recent_colours.push_back(pix);
         if (recent_colours.size() > 64) begin
            void'(recent_colours.pop_front());
         end
      end
      if ($urandom_range(0, 29) == 0) begin
         gap_on = !gap_on;
      end
   endtask

   task automatic random_beat(input int fresh_pct);
      int                          roll;
      logic [tpb_pkg::COLOR_W-1:0] pix;
      logic [tpb_pkg::COLOR_W-1:0] base;
      logic [7:0]                  delta;
      roll = $urandom_range(0, 99);
      pix  = tpb_pkg::COLOR_W'($urandom());
      if (roll < 12) begin
         offer(tpb_pkg::MODE_READ, pix, tpb_pkg::INDEX_W'($urandom_range(0, 255)));
      end else begin
         if (roll < 22) begin
            for (int ch = 0; ch < 3; ch++) begin
               pix[8*ch +: 8] = TRICKY_LEVELS[$urandom_range(0, 8)];
            end
         end else if (roll >= 22 + fresh_pct && recent_colours.size() != 0) begin
            // nudge each channel of a recent colour by up to two steps
            base = recent_colours[$urandom_range(0, recent_colours.size() - 1)];
            for (int ch = 0; ch < 3; ch++) begin
               delta = 8'($urandom_range(0, 4)) - 8'd2;
               pix[8*ch +: 8] = base[8*ch +: 8] + delta;
            end
         end
         offer(tpb_pkg::MODE_MAP, pix, tpb_pkg::INDEX_W'($urandom_range(0, 255)));
      end
   endtask

   // response side: random stall bursts, one long hold-off
   initial begin
      int  taken;
      int  hold_left;
      int  stall_left;
      bit  held;
      bit  stall_on;
      taken      = 0;
      hold_left  = 0;
      stall_left = 0;
      held       = 1'b0;
      stall_on   = 1'b1;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            taken++;
         end
         if (!held && taken == HOLD_AFTER) begin
            held      = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (!calm && stall_on && $urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(0, 8);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
         if ($urandom_range(0, 99) == 0) begin
            stall_on = !stall_on;
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Some tests failed");
      $finish;
   end

   initial begin
      int seg_len;
      int fresh_pct;
      sent   = 0;
      calm   = 1'b0;
      gap_on = 1'b1;
      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.mode         <= tpb_pkg::MODE_MAP;
      req_bus.pixel_color  <= '0;
      req_bus.entry_number <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // presets, tolerance edges and saturated channels
      offer(tpb_pkg::MODE_READ,  24'h000000, 8'd0);
      offer(tpb_pkg::MODE_READ,  24'hFFFFFF, 8'd255);
      offer(tpb_pkg::MODE_MAP,   24'hC0C0C0, 8'd0);
      offer(tpb_pkg::MODE_MAP,   24'hBFBFBF, 8'd255);
      offer(tpb_pkg::MODE_MAP,   24'hC1C1C1, 8'd0);
      offer(tpb_pkg::MODE_MAP,   24'hFFFFFF, 8'd0);
      offer(tpb_pkg::MODE_MAP,   24'hFEFEFE, 8'd255);
      offer(tpb_pkg::MODE_MAP,   24'h7F7F7F, 8'd0);
      offer(tpb_pkg::MODE_MAP,   24'h000000, 8'd0);
      offer(tpb_pkg::MODE_MAP,   24'h010101, 8'd0);
      offer(tpb_pkg::MODE_MAP,   24'h020202, 8'd0);
      offer(tpb_pkg::MODE_MAP,   24'hFFFFFE, 8'd0);
      offer(tpb_pkg::MODE_MAP,   24'hC0C1BF, 8'd0);
      offer(tpb_pkg::MODE_MAP,   24'h80FF00, 8'd0);
      offer(tpb_pkg::MODE_READ,  24'h000000, 8'd4);
      offer(tpb_pkg::MODE_READ,  24'h000000, 8'd7);
      offer(tpb_pkg::MODE_READ,  24'hFFFFFF, 8'd200);
      offer(tpb_pkg::MODE_CLEAR, 24'hFFFFFF, 8'd255);
      offer(tpb_pkg::MODE_READ,  24'h000000, 8'd4);
      offer(tpb_pkg::MODE_MAP,   24'hFFFFFF, 8'd255);
      offer(tpb_pkg::MODE_MAP,   24'h000000, 8'd0);

      // first random segment long and fresh-heavy so the palette fills up
      offer(tpb_pkg::MODE_CLEAR, tpb_pkg::COLOR_W'($urandom()),
            tpb_pkg::INDEX_W'($urandom()));
      for (int k = 0; k < 600; k++) begin
         random_beat(60);
      end
      while (sent < TOTAL_BEATS) begin
         offer(tpb_pkg::MODE_CLEAR, tpb_pkg::COLOR_W'($urandom()),
               tpb_pkg::INDEX_W'($urandom()));
         seg_len   = ($urandom_range(0, 4) == 0) ? 400 : $urandom_range(10, 120);
         fresh_pct = (seg_len > 200) ? 60 : $urandom_range(15, 45);
         for (int k = 0; k < seg_len && sent < TOTAL_BEATS; k++) begin
            random_beat(fresh_pct);
         end
      end
      req_bus.valid <= 1'b0;

      do @(posedge clock); while (pending != 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d request beats: %0d matches, %0d appends, %0d full fallbacks,",
               sent, n_hits, n_appends, n_fulls);
      $display("%0d entry reads and %0d clears, with idle bursts and one long hold-off.",
               n_reads, n_clears);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
